// ===== design/rgbepp_pkg.sv =====
// Shared types, constants and register codes of the RGB to e-paper plane packer.
`timescale 1ns / 1ps

package rgbepp_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 2;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned CodeW    = 2;
  localparam int unsigned LumaW    = 15;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PLANE_MODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INVERT_BITS = 2'd1;

  // plane modes; the unused code behaves as luminance
  localparam logic [1:0] MODE_GREY = 2'd0;
  localparam logic [1:0] MODE_RED  = 2'd1;
  localparam logic [1:0] MODE_LUMA = 2'd2;

  // grey plane codes
  localparam logic [CodeW-1:0] GREY_INK_NONE = 2'b00;
  localparam logic [CodeW-1:0] GREY_INK_MID  = 2'b01;
  localparam logic [CodeW-1:0] GREY_INK_FULL = 2'b11;

  localparam logic [ChanW-1:0] GREY_HI = 8'd171;
  localparam logic [ChanW-1:0] GREY_LO = 8'd85;
  localparam logic [ChanW-1:0] RED_HI  = 8'd171;
  localparam logic [ChanW-1:0] RED_LO  = 8'd110;

  // luminance weights in hundredths
  localparam logic [LumaW-1:0] LUMA_KR    = 15'd21;
  localparam logic [LumaW-1:0] LUMA_KG    = 15'd72;
  localparam logic [LumaW-1:0] LUMA_KB    = 15'd7;
  localparam logic [LumaW-1:0] LUMA_LIMIT = 15'd12700;

  typedef struct packed {
    logic [1:0] plane_mode;
    logic       invert_bits;
  } cfg_t;

endpackage

// ===== design/rgbepp_if.sv =====
// Handshake channels for pixels, packed bytes and configuration writes.
`timescale 1ns / 1ps

interface rgbepp_pix_if;
  logic                          valid;
  logic                          ready;
  logic [rgbepp_pkg::ChanW-1:0]  red_level;
  logic [rgbepp_pkg::ChanW-1:0]  green_level;
  logic [rgbepp_pkg::ChanW-1:0]  blue_level;
  logic                          row_end;

  modport source (output valid, red_level, green_level, blue_level, row_end, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, row_end, output ready);
endinterface

interface rgbepp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [rgbepp_pkg::ByteW-1:0]  packed_byte;
  logic                          row_last;

  modport source (output valid, packed_byte, row_last, input ready);
  modport sink   (input valid, packed_byte, row_last, output ready);
endinterface

interface rgbepp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rgbepp_pkg::CfgIdxW-1:0]   reg_index;
  logic [rgbepp_pkg::CfgDataW-1:0]  wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== design/rgbepp_classify.sv =====
// Pixel classifier: ink code of one RGB pixel for the selected plane.
`timescale 1ns / 1ps

module rgbepp_classify (
  input  rgbepp_pkg::cfg_t                cfg,
  input  logic [rgbepp_pkg::ChanW-1:0]    red,
  input  logic [rgbepp_pkg::ChanW-1:0]    green,
  input  logic [rgbepp_pkg::ChanW-1:0]    blue,
  output logic [rgbepp_pkg::CodeW-1:0]    code
);

  logic                         is_red;
  logic                         is_white;
  logic                         is_mid;
  logic                         red_ink;
  logic                         luma_ink;
  logic [rgbepp_pkg::LumaW-1:0] luma;

  assign is_red   = (red > rgbepp_pkg::GREY_HI) && (green < rgbepp_pkg::GREY_LO)
                    && (blue < rgbepp_pkg::GREY_LO);
  assign is_white = (red > rgbepp_pkg::GREY_HI) && (green > rgbepp_pkg::GREY_HI)
                    && (blue > rgbepp_pkg::GREY_HI);
  assign is_mid   = (red > rgbepp_pkg::GREY_LO) && (red < rgbepp_pkg::GREY_HI)
                    && (green > rgbepp_pkg::GREY_LO) && (green < rgbepp_pkg::GREY_HI)
                    && (blue > rgbepp_pkg::GREY_LO) && (blue < rgbepp_pkg::GREY_HI);

  assign red_ink  = (red > rgbepp_pkg::RED_HI) && (green < rgbepp_pkg::RED_LO)
                    && (blue < rgbepp_pkg::RED_LO);

  // weighted sum stays below 2^15 for 8-bit channels
  assign luma     = rgbepp_pkg::LUMA_KR * rgbepp_pkg::LumaW'(red)
                  + rgbepp_pkg::LUMA_KG * rgbepp_pkg::LumaW'(green)
                  + rgbepp_pkg::LUMA_KB * rgbepp_pkg::LumaW'(blue);
  assign luma_ink = (luma < rgbepp_pkg::LUMA_LIMIT);

  always_comb begin
    code = rgbepp_pkg::GREY_INK_FULL;
    unique case (cfg.plane_mode)
      rgbepp_pkg::MODE_GREY: begin
        if (is_red || is_white) begin
          code = rgbepp_pkg::GREY_INK_NONE;
        end else if (is_mid) begin
          code = rgbepp_pkg::GREY_INK_MID;
        end else begin
          code = rgbepp_pkg::GREY_INK_FULL;
        end
      end
      rgbepp_pkg::MODE_RED: begin
        code = {1'b0, red_ink ^ cfg.invert_bits};
      end
      default: begin
        code = {1'b0, luma_ink ^ cfg.invert_bits};
      end
    endcase
  end

endmodule

// ===== design/rgb_to_epaper_plane_packer.sv =====
// Top level: pixel register, plane classification, bit packing and byte output register.
// A pixel is held in the pixel register, its byte in the byte output register.
// Throughput: one pixel per cycle; the accumulator and slot counter update once per pixel.
// A stalled byte output holds back only pixels that would complete another byte.
// Reset (synchronous, active low) clears config, valid flags, accumulator and slot count.
`timescale 1ns / 1ps

module rgb_to_epaper_plane_packer (
  input  logic                 clk,
  input  logic                 rst_n,
  rgbepp_pix_if.sink           in_px,
  rgbepp_byte_if.source        out_bt,
  rgbepp_cfg_if.sink           cfg_wr
);

  rgbepp_pkg::cfg_t                  cfg_r;
  rgbepp_pkg::cfg_t                  cfg_nxt;

  logic                              pix_valid_r;
  logic                              pix_valid_nxt;
  logic [rgbepp_pkg::ChanW-1:0]      pix_red_r;
  logic [rgbepp_pkg::ChanW-1:0]      pix_green_r;
  logic [rgbepp_pkg::ChanW-1:0]      pix_blue_r;
  logic                              pix_last_r;

  logic [rgbepp_pkg::ByteW-1:0]      acc_r;
  logic [rgbepp_pkg::ByteW-1:0]      acc_nxt;
  logic [rgbepp_pkg::SlotW-1:0]      slot_r;
  logic [rgbepp_pkg::SlotW-1:0]      slot_nxt;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [rgbepp_pkg::ByteW-1:0]      out_byte_r;
  logic                              out_last_r;

  logic [rgbepp_pkg::CodeW-1:0]      code;
  logic                              grey;
  logic [3:0]                        used;
  logic [4:0]                        used_end;
  logic                              fits;
  logic                              full;
  logic                              emit;
  logic [2:0]                        shift;
  logic [rgbepp_pkg::ByteW-1:0]      acc_merged;
  logic                              out_free;
  logic                              pix_fire;
  logic                              in_fire;

  rgbepp_classify u_classify (
    .cfg   (cfg_r),
    .red   (pix_red_r),
    .green (pix_green_r),
    .blue  (pix_blue_r),
    .code  (code)
  );

  // configuration writes; indexes beyond the list are dropped
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.reg_index)
        rgbepp_pkg::REG_PLANE_MODE:  cfg_nxt.plane_mode  = cfg_wr.wr_data[1:0];
        rgbepp_pkg::REG_INVERT_BITS: cfg_nxt.invert_bits = cfg_wr.wr_data[0];
        default: ;
      endcase
    end
  end

  // packing: grey codes take two bits, mono codes one
  assign grey     = (cfg_r.plane_mode == rgbepp_pkg::MODE_GREY);
  assign used     = grey ? {slot_r, 1'b0} : {1'b0, slot_r};
  assign used_end = {1'b0, used} + (grey ? 5'd2 : 5'd1);
  assign fits     = (used_end <= 5'd8);
  assign shift    = 3'(5'd8 - used_end);
  assign acc_merged = acc_r | ({6'b0, code} << shift);
  // a code that no longer fits is dropped and the byte goes out as it stands
  assign full     = !fits || (used_end == 5'd8);
  assign emit     = full || pix_last_r;

  assign out_free = !out_valid_r || out_bt.ready;
  assign pix_fire = pix_valid_r && (!emit || out_free);
  assign in_fire  = in_px.valid && in_px.ready;
  assign in_px.ready = !pix_valid_r || pix_fire;

  always_comb begin
    acc_nxt  = acc_r;
    slot_nxt = slot_r;
    if (pix_fire) begin
      if (emit) begin
        acc_nxt  = '0;
        slot_nxt = '0;
      end else begin
        acc_nxt  = acc_merged;
        slot_nxt = slot_r + 3'd1;
      end
    end
  end

  always_comb begin
    pix_valid_nxt = pix_valid_r;
    if (in_fire) begin
      pix_valid_nxt = 1'b1;
    end else if (pix_fire) begin
      pix_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pix_fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bt.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      pix_valid_r <= 1'b0;
      acc_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      pix_valid_r <= pix_valid_nxt;
      acc_r       <= acc_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_red_r   <= in_px.red_level;
      pix_green_r <= in_px.green_level;
      pix_blue_r  <= in_px.blue_level;
      pix_last_r  <= in_px.row_end;
    end
    if (pix_fire && emit) begin
      out_byte_r <= fits ? acc_merged : acc_r;
      out_last_r <= pix_last_r;
    end
  end

  assign out_bt.valid       = out_valid_r;
  assign out_bt.packed_byte = out_byte_r;
  assign out_bt.row_last    = out_last_r;

endmodule

// ===== bench/rgb_to_epaper_plane_packer_test.sv =====
// Self-checking bench for the RGB to e-paper plane packer: directed table, then random pixel rows.
`timescale 1ns / 1ps

module rgb_to_epaper_plane_packer_test;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_PIXELS  = 48;

  // indexes with no register behind them, and the plane mode with no name of its own
  localparam logic [rgbepp_pkg::CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [rgbepp_pkg::CfgIdxW-1:0] REG_SPARE_B = 2'd3;
  localparam logic [1:0]                     MODE_SPARE  = 2'd3;

  typedef struct packed {
    logic [rgbepp_pkg::ChanW-1:0] red, green, blue;
    logic                         row_end;
  } pixel_t;

  typedef struct packed {
    logic [rgbepp_pkg::ByteW-1:0] packed_byte;
    logic                         row_last;
  } plane_byte_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t                      kind;
    pixel_t                          px;
    logic [rgbepp_pkg::CfgIdxW-1:0]  reg_idx;
    logic [rgbepp_pkg::CfgDataW-1:0] reg_data;
    bit                              typed;
    plane_byte_t                     typed_byte;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rgbepp_pix_if  pixel_ch ();
  rgbepp_byte_if plane_ch ();
  rgbepp_cfg_if  cfg_ch ();

  rgb_to_epaper_plane_packer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (pixel_ch),
    .out_bt (plane_ch),
    .cfg_wr (cfg_ch)
  );

  always #2 clk = ~clk;

  // predictor state
  rgbepp_pkg::cfg_t             plane_cfg    = '0;
  logic [rgbepp_pkg::ByteW-1:0] acc_bits     = '0;
  logic [rgbepp_pkg::SlotW-1:0] filled_slots = '0;
  plane_byte_t                  byte_fifo[$];

  // typed expectation that travels with the pixel on the wire
  logic        row_typed;
  plane_byte_t row_typed_byte;

  int errors       = 0;
  int quiet_cycles = 0;
  bit long_hold_req = 1'b0;

  function automatic logic [rgbepp_pkg::CodeW-1:0] grey_class(input pixel_t px);
    logic [rgbepp_pkg::ChanW-1:0] lo;
    logic [rgbepp_pkg::ChanW-1:0] hi;
    lo = rgbepp_pkg::GREY_LO;
    hi = rgbepp_pkg::GREY_HI;
    if (px.red > hi && px.green < lo && px.blue < lo) return rgbepp_pkg::GREY_INK_NONE;
    if (px.red > hi && px.green > hi && px.blue > hi) return rgbepp_pkg::GREY_INK_NONE;
    if (px.red > lo && px.red < hi && px.green > lo && px.green < hi &&
        px.blue > lo && px.blue < hi) return rgbepp_pkg::GREY_INK_MID;
    return rgbepp_pkg::GREY_INK_FULL;
  endfunction

  function automatic logic mono_ink(input pixel_t px, input rgbepp_pkg::cfg_t c);
    int   luma;
    logic ink;
    luma = int'(rgbepp_pkg::LUMA_KR) * int'(px.red) +
           int'(rgbepp_pkg::LUMA_KG) * int'(px.green) +
           int'(rgbepp_pkg::LUMA_KB) * int'(px.blue);
    if (c.plane_mode == rgbepp_pkg::MODE_RED)
      ink = (px.red > rgbepp_pkg::RED_HI) && (px.green < rgbepp_pkg::RED_LO) &&
            (px.blue < rgbepp_pkg::RED_LO);
    else
      ink = luma < int'(rgbepp_pkg::LUMA_LIMIT);
    return ink ^ c.invert_bits;
  endfunction

  // place one pixel's code in the byte; emit when full or at the row end
  function automatic void pack_pixel(input pixel_t px, output bit emit, output plane_byte_t res);
    int                           width;
    int                           used;
    int                           code;
    int                           shifted;
    logic [rgbepp_pkg::ByteW-1:0] placed;
    bit                           full;
    width = (plane_cfg.plane_mode == rgbepp_pkg::MODE_GREY) ? 2 : 1;
    code  = (plane_cfg.plane_mode == rgbepp_pkg::MODE_GREY) ? int'(grey_class(px))
                                                            : int'(mono_ink(px, plane_cfg));
    used  = int'(filled_slots) * width;
    full  = 1'b1;
    if (used + width <= rgbepp_pkg::ByteW) begin
      shifted  = code << (rgbepp_pkg::ByteW - used - width);
      placed   = shifted[rgbepp_pkg::ByteW-1:0];
      acc_bits = acc_bits | placed;
      full     = (used + width >= rgbepp_pkg::ByteW);
    end
    emit            = full || px.row_end;
    res.packed_byte = acc_bits;
    res.row_last    = px.row_end;
    if (emit) begin
      acc_bits     = '0;
      filled_slots = '0;
    end else begin
      filled_slots = filled_slots + 1'b1;
    end
  endfunction

  function automatic logic [rgbepp_pkg::ChanW-1:0] edge_level();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return rgbepp_pkg::GREY_LO - 8'd1;
      2:       return rgbepp_pkg::GREY_LO;
      3:       return rgbepp_pkg::GREY_LO + 8'd1;
      4:       return rgbepp_pkg::RED_LO - 8'd1;
      5:       return rgbepp_pkg::RED_LO;
      6:       return rgbepp_pkg::GREY_HI - 8'd1;
      7:       return rgbepp_pkg::GREY_HI;
      8:       return rgbepp_pkg::GREY_HI + 8'd1;
      default: return 8'd255;
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     rest;
    int     g;
    px.row_end = 1'b0;
    case ($urandom_range(0, 3))
      0: begin
        px.red   = edge_level();
        px.green = edge_level();
        px.blue  = edge_level();
      end
      1: begin
        // land on or next to the luminance threshold
        px.red  = 8'($urandom_range(0, 255));
        px.blue = 8'($urandom_range(0, 255));
        rest    = int'(rgbepp_pkg::LUMA_LIMIT) - int'(rgbepp_pkg::LUMA_KR) * int'(px.red) -
                  int'(rgbepp_pkg::LUMA_KB) * int'(px.blue);
        g       = rest / int'(rgbepp_pkg::LUMA_KG) + int'($urandom_range(0, 2)) - 1;
        if (g < 0) g = 0;
        if (g > 255) g = 255;
        px.green = 8'(g);
      end
      default: begin
        px.red   = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue  = 8'($urandom_range(0, 255));
      end
    endcase
    return px;
  endfunction

  function automatic plan_row_t pix_row(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic last,
                                        input bit typed = 1'b0,
                                        input logic [7:0] byte_val = 8'h00);
    plan_row_t row;
    row.kind       = STEP_PIXEL;
    row.px         = {r, g, b, last};
    row.reg_idx    = '0;
    row.reg_data   = '0;
    row.typed      = typed;
    row.typed_byte = {byte_val, last};
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [rgbepp_pkg::CfgIdxW-1:0] idx,
                                        input logic [rgbepp_pkg::CfgDataW-1:0] data);
    plan_row_t row;
    row.kind       = STEP_WRITE;
    row.px         = '0;
    row.reg_idx    = idx;
    row.reg_data   = data;
    row.typed      = 1'b0;
    row.typed_byte = '0;
    return row;
  endfunction

  // offer one pixel and return at the edge of its transfer
  task automatic send_pixel(input pixel_t px, input bit typed, input plane_byte_t typed_byte);
    pixel_ch.valid       <= 1'b1;
    pixel_ch.red_level   <= px.red;
    pixel_ch.green_level <= px.green;
    pixel_ch.blue_level  <= px.blue;
    pixel_ch.row_end     <= px.row_end;
    row_typed            <= typed;
    row_typed_byte       <= typed_byte;
    do @(negedge clk); while (!pixel_ch.ready);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [rgbepp_pkg::CfgIdxW-1:0] idx,
                           input logic [rgbepp_pkg::CfgDataW-1:0] data,
                           input bit last_write);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    if (last_write) cfg_ch.valid <= 1'b0;
  endtask

  // hold the pixel side until every predicted byte is out, then let the pipeline settle
  task automatic drain_bytes();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (byte_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin : scoreboard
    bit          emit;
    bit          moved;
    plane_byte_t res;
    plane_byte_t want;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        case (cfg_ch.reg_index)
          rgbepp_pkg::REG_PLANE_MODE:  plane_cfg.plane_mode  = cfg_ch.wr_data;
          rgbepp_pkg::REG_INVERT_BITS: plane_cfg.invert_bits = cfg_ch.wr_data[0];
          default: ;
        endcase
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        moved = 1'b1;
        pack_pixel({pixel_ch.red_level, pixel_ch.green_level, pixel_ch.blue_level,
                    pixel_ch.row_end}, emit, res);
        if (row_typed) byte_fifo.push_back(row_typed_byte);
        else if (emit) byte_fifo.push_back(res);
      end
      if (plane_ch.valid && plane_ch.ready) begin
        moved = 1'b1;
        if (byte_fifo.size() == 0) begin
          $display("%0t: byte %02h row_last %0b with none expected", $time,
                   plane_ch.packed_byte, plane_ch.row_last);
          errors++;
        end else begin
          want = byte_fifo.pop_front();
          if (plane_ch.packed_byte !== want.packed_byte) begin
            $display("%0t: packed_byte expected %02h got %02h", $time,
                     want.packed_byte, plane_ch.packed_byte);
            errors++;
          end
          if (plane_ch.row_last !== want.row_last) begin
            $display("%0t: row_last expected %0b got %0b", $time,
                     want.row_last, plane_ch.row_last);
            errors++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : byte_sink
    logic [15:0] ready_pattern;
    int          hold_left;
    int          since_redraw;
    ready_pattern = 16'hFFFF;
    hold_left     = 0;
    since_redraw  = 0;
    plane_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (since_redraw == 0) begin
        since_redraw  = $urandom_range(20, 80);
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end
      since_redraw--;
      ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
      plane_ch.ready <= (hold_left == 0) && ready_pattern[0];
    end
  end

  initial begin : stimulus
    plan_row_t                       plan[$];
    pixel_t                          px;
    logic [rgbepp_pkg::CfgDataW-1:0] mode_val;
    logic [rgbepp_pkg::CfgDataW-1:0] inv_val;
    int                              burst_left;
    int                              gap;
    int                              row_len;
    int                              row_pos;
    bit                              no_gaps;
    rst_n                <= 1'b0;
    pixel_ch.valid       <= 1'b0;
    pixel_ch.red_level   <= '0;
    pixel_ch.green_level <= '0;
    pixel_ch.blue_level  <= '0;
    pixel_ch.row_end     <= 1'b0;
    row_typed            <= 1'b0;
    row_typed_byte       <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.reg_index     <= '0;
    cfg_ch.wr_data       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // grey plane after reset: white, red, mid grey, black make a full byte at row end
    plan.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b0));
    plan.push_back(pix_row(8'd255, 8'd0,   8'd0,   1'b0));
    plan.push_back(pix_row(8'd128, 8'd128, 8'd128, 1'b0));
    plan.push_back(pix_row(8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'h07));
    plan.push_back(pix_row(8'd171, 8'd171, 8'd171, 1'b1, 1'b1, 8'hC0));
    plan.push_back(pix_row(8'd86,  8'd170, 8'd86,  1'b0));
    plan.push_back(pix_row(8'd172, 8'd84,  8'd84,  1'b1, 1'b1, 8'h40));
    // leave one grey code in the byte, then switch to the red plane
    plan.push_back(pix_row(8'd85,  8'd85,  8'd85,  1'b0));
    plan.push_back(reg_row(rgbepp_pkg::REG_PLANE_MODE, rgbepp_pkg::MODE_RED));
    plan.push_back(pix_row(8'd172, 8'd109, 8'd109, 1'b1));
    plan.push_back(pix_row(8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 8'h80));
    plan.push_back(reg_row(rgbepp_pkg::REG_INVERT_BITS, 2'd1));
    plan.push_back(pix_row(8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 8'h00));
    plan.push_back(pix_row(8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'h80));
    plan.push_back(reg_row(rgbepp_pkg::REG_PLANE_MODE, rgbepp_pkg::MODE_LUMA));
    plan.push_back(reg_row(rgbepp_pkg::REG_INVERT_BITS, 2'd0));
    plan.push_back(pix_row(8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'h80));
    plan.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'h00));
    // exactly on the luminance threshold, then one below it
    plan.push_back(pix_row(8'd100, 8'd141, 8'd64,  1'b0));
    plan.push_back(pix_row(8'd100, 8'd141, 8'd63,  1'b1, 1'b1, 8'h40));
    plan.push_back(reg_row(rgbepp_pkg::REG_PLANE_MODE, MODE_SPARE));
    plan.push_back(pix_row(8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'h80));
    // seven mono bits, then a grey code that no longer fits forces the byte out
    repeat (7) plan.push_back(pix_row(8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(reg_row(rgbepp_pkg::REG_PLANE_MODE, rgbepp_pkg::MODE_GREY));
    plan.push_back(pix_row(8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'hFE));

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        drain_bytes();
        write_reg(plan[i].reg_idx, plan[i].reg_data, 1'b1);
      end else begin
        send_pixel(plan[i].px, plan[i].typed, plan[i].typed_byte);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_bytes();
      mode_val = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
      inv_val  = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
      write_reg(rgbepp_pkg::REG_PLANE_MODE, mode_val, 1'b0);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  2'($urandom_range(0, 3)), 1'b0);
      write_reg(rgbepp_pkg::REG_INVERT_BITS, inv_val, 1'b1);
      no_gaps    = (p % 3 == 1);
      // hold the byte side off while pixels keep coming
      if (p == 5) long_hold_req = 1'b1;
      row_len    = 0;
      row_pos    = 0;
      burst_left = $urandom_range(1, 16);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (row_pos >= row_len) begin
          row_pos = 0;
          row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        end
        row_pos++;
        px         = random_pixel();
        px.row_end = (row_pos == row_len);
        // now and then a broken row marker
        if ($urandom_range(0, 15) == 0) px.row_end = ~px.row_end;
        if (p == 6 && n == PHASE_PIXELS / 2) begin
          drain_bytes();
        end else if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap        = no_gaps ? 0 : $urandom_range(0, 8);
          if (gap > 0) begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        send_pixel(px, 1'b0, '0);
      end
    end

    drain_bytes();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
